[rtl/core/modular_exponentiation_64_assert.svh]
// ----------------------------------------------------------------------------
// modular exponentiation assertion macros
// shared property templates, clocked on clk_i and disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_64_ASSERT_SVH
`define MODULAR_EXPONENTIATION_64_ASSERT_SVH

// same-cycle implication
`define MEXP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mexp assertion failed");

// next-cycle implication
`define MEXP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mexp assertion failed");

`endif

[rtl/core/mexp_pkg.sv]
// ----------------------------------------------------------------------------
// mexp_pkg
// shared types for the modular exponentiation controller and datapath
// ----------------------------------------------------------------------------
package mexp_pkg;

  // width of every item field on the ports
  localparam int FIELD_BITS = 64;

  // controller states, one-hot
  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_CHECK   = 10'b00_0000_0010,
    ST_REDUCE  = 10'b00_0000_0100,
    ST_RED_END = 10'b00_0000_1000,
    ST_EXP     = 10'b00_0001_0000,
    ST_MUL_ACC = 10'b00_0010_0000,
    ST_ACC_WB  = 10'b00_0100_0000,
    ST_MUL_SQR = 10'b00_1000_0000,
    ST_SQR_WB  = 10'b01_0000_0000,
    ST_DONE    = 10'b10_0000_0000
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;        // capture operands, acc = 1
    logic red_step;    // one bit of base mod modulus
    logic red_done;    // base = remainder
    logic mul_start;   // set up the bit-serial multiplier
    logic mul_sel_acc; // multiply acc by base, else base by base
    logic mul_step;    // one add-double step
    logic acc_write;   // acc = product
    logic b_write;     // base = product, shift exponent
    logic finish;      // latch the result
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic m_le1;    // modulus is 0 or 1
    logic e_zero;   // no exponent bits left
    logic e_lsb;    // current exponent bit
    logic cnt_last; // step counter at its last step
  } sts_t;

endpackage

[rtl/core/mexp_dp.sv]
// ----------------------------------------------------------------------------
// mexp_dp
// datapath: operand registers, serial remainder unit for the base reduction
// and a shared bit-serial modular multiplier (add-double per cycle)
// ----------------------------------------------------------------------------
module mexp_dp import mexp_pkg::*; #(
  parameter int WORD_BITS = 64
) (
  input  logic                  clk_i,
  input  logic [FIELD_BITS-1:0] base_value_i,
  input  logic [FIELD_BITS-1:0] exponent_value_i,
  input  logic [FIELD_BITS-1:0] modulus_value_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  output logic [FIELD_BITS-1:0] power_result_o
);

  localparam int CW = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] m_q, b_q, e_q, acc_q, rem_q;
  logic [WORD_BITS-1:0] ma_q, mb_q, mp_q, result_q;
  logic [CW-1:0]        cnt_q;

  logic [WORD_BITS:0]   rem_shift, rem_sub;
  logic [WORD_BITS-1:0] rem_d, mp_add, ma_dbl;

  // (a + b) mod m for a, b < m
  function automatic logic [WORD_BITS-1:0] mod_add(
    input logic [WORD_BITS-1:0] a,
    input logic [WORD_BITS-1:0] b,
    input logic [WORD_BITS-1:0] m
  );
    logic [WORD_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[WORD_BITS-1:0];
  endfunction

  // restoring remainder step, base msb first
  always_comb begin
    rem_shift = {rem_q, b_q[WORD_BITS-1]};
    rem_sub   = rem_shift - {1'b0, m_q};
    rem_d     = (rem_shift >= {1'b0, m_q}) ? rem_sub[WORD_BITS-1:0]
                                           : rem_shift[WORD_BITS-1:0];
  end

  // multiplier add and double
  assign mp_add = mod_add(mp_q, ma_q, m_q);
  assign ma_dbl = mod_add(ma_q, ma_q, m_q);

  // operand and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m_q   <= modulus_value_i[WORD_BITS-1:0];
      b_q   <= base_value_i[WORD_BITS-1:0];
      e_q   <= exponent_value_i[WORD_BITS-1:0];
      acc_q <= WORD_BITS'(1);
      rem_q <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.red_step) begin
      rem_q <= rem_d;
      b_q   <= {b_q[WORD_BITS-2:0], 1'b0};
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.red_done) begin
      b_q <= rem_q;
    end
    if (cmd_i.mul_start) begin
      ma_q  <= b_q;
      mb_q  <= cmd_i.mul_sel_acc ? acc_q : b_q;
      mp_q  <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.mul_step) begin
      if (mb_q[0]) begin
        mp_q <= mp_add;
      end
      ma_q  <= ma_dbl;
      mb_q  <= mb_q >> 1;
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.acc_write) begin
      acc_q <= mp_q;
    end
    if (cmd_i.b_write) begin
      b_q <= mp_q;
      e_q <= e_q >> 1;
    end
    if (cmd_i.finish) begin
      result_q <= sts_o.m_le1 ? '0 : acc_q;
    end
  end

  // status back to the controller
  always_comb begin
    sts_o.m_le1    = (m_q[WORD_BITS-1:1] == '0);
    sts_o.e_zero   = (e_q == '0);
    sts_o.e_lsb    = e_q[0];
    sts_o.cnt_last = (cnt_q == CW'(WORD_BITS - 1));
  end

  assign power_result_o = FIELD_BITS'(result_q);

endmodule

[rtl/core/mexp_ctrl.sv]
// ----------------------------------------------------------------------------
// mexp_ctrl
// controller: sequences reduction, exponent scan and the multiplier passes
// ----------------------------------------------------------------------------
module mexp_ctrl import mexp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy,
  output logic done_o
);

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.m_le1) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_DONE;
        end else begin
          state_d = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd_o.red_step = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = ST_RED_END;
        end
      end
      ST_RED_END: begin
        cmd_o.red_done = 1'b1;
        state_d        = ST_EXP;
      end
      ST_EXP: begin
        if (sts_i.e_zero) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_DONE;
        end else begin
          cmd_o.mul_start   = 1'b1;
          cmd_o.mul_sel_acc = sts_i.e_lsb;
          state_d           = sts_i.e_lsb ? ST_MUL_ACC : ST_MUL_SQR;
        end
      end
      ST_MUL_ACC: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = ST_ACC_WB;
        end
      end
      ST_ACC_WB: begin
        cmd_o.acc_write = 1'b1;
        cmd_o.mul_start = 1'b1;
        state_d         = ST_MUL_SQR;
      end
      ST_MUL_SQR: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = ST_SQR_WB;
        end
      end
      ST_SQR_WB: begin
        cmd_o.b_write = 1'b1;
        state_d       = ST_EXP;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

endmodule

[rtl/core/modular_exponentiation_64.sv]
// ----------------------------------------------------------------------------
// modular_exponentiation_64
// base^exponent mod modulus by right-to-left square-and-multiply
// ----------------------------------------------------------------------------
// channel  direction  handshake             payload
// command  in         start high, busy low  base_value_i, exponent_value_i,
//                                           modulus_value_i
// result   out        done_o, one cycle     power_result_o
//
// one item at a time; busy stays high from accept until the done_o cycle
// after accept the controller enters check; for modulus 0 or 1 it goes from there
// straight to done, with no reduction and no exponent scan
// otherwise the base is reduced mod modulus, then the exponent is scanned lsb first:
// a set bit runs a multiply of acc by base, and every bit runs a squaring of base
// the single bit-serial multiplier does one add-double a cycle
// reset clears only the controller; the receiver cannot stall done_o
// ----------------------------------------------------------------------------
`include "modular_exponentiation_64_assert.svh"

module modular_exponentiation_64 import mexp_pkg::*; #(
  parameter int WORD_BITS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [FIELD_BITS-1:0] base_value_i,
  input  logic [FIELD_BITS-1:0] exponent_value_i,
  input  logic [FIELD_BITS-1:0] modulus_value_i,
  output logic                  done_o,
  output logic [FIELD_BITS-1:0] power_result_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  mexp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  // arithmetic
  mexp_dp #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .base_value_i     (base_value_i),
    .exponent_value_i (exponent_value_i),
    .modulus_value_i  (modulus_value_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .power_result_o   (power_result_o)
  );

  // checks
  `MEXP_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done_o)
  `MEXP_ASSERT_NOW(a_done_in_flight, done_o, busy && !cmd.load)
  `MEXP_ASSERT_NEXT(a_done_pulse, done_o, !done_o && !busy)
  `MEXP_ASSERT_NEXT(a_small_mod,
    start && !busy && (modulus_value_i[WORD_BITS-1:0] < 2),
    ##1 (done_o && (power_result_o == '0)))

endmodule
